// ===== src/cs_pkg.sv =====
package cs_pkg;

  // Default configuration of the table
  localparam int DEF_MAX_ENTRIES = 64;
  localparam int DEF_PROB_BITS   = 16;

  // Fixed field widths
  localparam int ENTRY_INDEX_W = 6;
  localparam int VALUE_W       = 16;
  localparam int CFG_W         = 7;

  // Request kinds
  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_DRAW  = 1'b1
  } mode_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic mem_we;     // store the incoming probability
    logic sum_clr;    // start a draw: clear sum, capture the random value
    logic rd_en;      // read one table entry
    logic acc_en;     // add the entry read last cycle
    logic res_load;   // capture the draw result
    logic res_found;  // whether the captured result is a hit
    logic out_load;   // move the result into the output register
  } cs_cmd_t;

endpackage

// ===== src/cs_ctrl.sv =====
module cs_ctrl #(
  parameter int MAX_ENTRIES = cs_pkg::DEF_MAX_ENTRIES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         mode,
  output logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         cfg_wr_en,
  input  logic [cs_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                         hit,
  output cs_pkg::cs_cmd_t              cmd,
  output logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
  output logic [$clog2(MAX_ENTRIES)-1:0] chk_idx
);
  import cs_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  state_t          state;
  logic [CFG_W-1:0] cfg_count;
  logic [CW-1:0]   limit;
  logic [CW-1:0]   issue_idx;
  logic            chk_valid;

  logic            accept;
  logic            is_draw;
  logic            issue;
  logic            finish_hit;
  logic            finish_miss;
  logic            out_free;
  logic [LW-1:0]   cfg_wide;
  logic [LW-1:0]   max_wide;
  logic [CW-1:0]   limit_next;

  // Handshake and draw bookkeeping
  assign in_stall    = (state != ST_IDLE);
  assign accept      = in_valid && !in_stall;
  assign is_draw     = (mode == MODE_DRAW);
  assign issue       = (state == ST_WALK) && (issue_idx < limit);
  assign finish_hit  = chk_valid && hit;
  assign finish_miss = !chk_valid && (issue_idx == limit);
  assign out_free    = !out_valid || !out_stall;
  assign rd_addr     = issue_idx[AW-1:0];

  // Saturate the entry count at the table depth
  assign cfg_wide   = LW'(cfg_count);
  assign max_wide   = LW'(MAX_ENTRIES);
  assign limit_next = (cfg_wide > max_wide) ? CW'(MAX_ENTRIES) : CW'(cfg_wide);

  // Decode commands
  always_comb begin
    cmd           = '0;
    cmd.mem_we    = accept && !is_draw;
    cmd.sum_clr   = accept && is_draw;
    cmd.rd_en     = issue;
    cmd.acc_en    = (state == ST_WALK) && chk_valid;
    cmd.res_load  = (state == ST_WALK) && (finish_hit || finish_miss);
    cmd.res_found = finish_hit;
    cmd.out_load  = (state == ST_DONE) && out_free;
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cfg_count <= '0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
      limit     <= '0;
      issue_idx <= '0;
      chk_idx   <= '0;
    end else begin
      if (cfg_wr_en) begin
        cfg_count <= cfg_wr_data;
      end

      // Drop the result once taken, raise it on load
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept && is_draw) begin
            limit     <= limit_next;
            issue_idx <= '0;
            chk_valid <= 1'b0;
            state     <= ST_WALK;
          end
        end
        ST_WALK: begin
          // Advance the read pointer; the read data arrives in the next cycle
          if (issue) begin
            issue_idx <= issue_idx + 1'b1;
            chk_idx   <= issue_idx[AW-1:0];
          end
          chk_valid <= issue;
          if (finish_hit || finish_miss) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/cs_dp.sv =====
module cs_dp #(
  parameter int MAX_ENTRIES = cs_pkg::DEF_MAX_ENTRIES,
  parameter int PROB_BITS   = cs_pkg::DEF_PROB_BITS
) (
  input  logic                             clk,
  input  cs_pkg::cs_cmd_t                  cmd,
  input  logic [cs_pkg::ENTRY_INDEX_W-1:0] entry_index,
  input  logic [cs_pkg::VALUE_W-1:0]       value,
  input  logic [$clog2(MAX_ENTRIES)-1:0]   rd_addr,
  input  logic [$clog2(MAX_ENTRIES)-1:0]   chk_idx,
  output logic                             hit,
  output logic                             found,
  output logic [cs_pkg::ENTRY_INDEX_W-1:0] chosen_index
);
  import cs_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int IW = ((AW > ENTRY_INDEX_W) ? AW : ENTRY_INDEX_W) + 1;
  localparam int SW = PROB_BITS + AW + 1;

  logic [PROB_BITS-1:0] mem [MAX_ENTRIES];
  logic [PROB_BITS-1:0] rd_data;
  logic [VALUE_W-1:0]   rnd;
  logic [SW-1:0]        sum;
  logic [SW-1:0]        sum_next;
  logic                 res_found;
  logic [ENTRY_INDEX_W-1:0] res_idx;
  logic [IW-1:0]        wr_idx;
  logic                 wr_ok;

  // Range-check the write index against the table depth
  assign wr_idx = IW'(entry_index);
  assign wr_ok  = (wr_idx < IW'(MAX_ENTRIES));

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_we && wr_ok) begin
      mem[wr_idx[AW-1:0]] <= PROB_BITS'(value);
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Running sum and compare against the random value
  assign sum_next = sum + SW'(rd_data);
  assign hit      = (sum_next > SW'(rnd));

  always_ff @(posedge clk) begin
    if (cmd.sum_clr) begin
      sum <= '0;
      rnd <= value;
    end else if (cmd.acc_en) begin
      sum <= sum_next;
    end
    if (cmd.res_load) begin
      res_found <= cmd.res_found;
      res_idx   <= cmd.res_found ? ENTRY_INDEX_W'(chk_idx) : '0;
    end
    if (cmd.out_load) begin
      found        <= res_found;
      chosen_index <= res_idx;
    end
  end

endmodule

// ===== src/categorical_sampler_top.sv =====
// Inverse-CDF categorical sampler. A write request (mode 0) stores a Q0.PROB_BITS
// probability at entry_index and returns nothing; indexes at or beyond
// MAX_ENTRIES are dropped. A draw request (mode 1) walks the table from entry 0,
// one entry per cycle through the single table read port, and returns the first
// index whose running sum exceeds value (found=1), or found=0 with index 0. The
// walk reads at most N = min(entries_in_use, MAX_ENTRIES) entries. A draw holds
// the input stalled while it walks and until its result moves into the output
// register, which waits while the previous result there is not yet taken; the
// result is offered at the edge that ends the stall.
// The next request is taken while a finished result waits in the output
// register. Write entries_in_use only while no draw is under way, and write
// every entry below it before drawing.
module categorical_sampler_top #(
  parameter int MAX_ENTRIES = cs_pkg::DEF_MAX_ENTRIES,
  parameter int PROB_BITS   = cs_pkg::DEF_PROB_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             mode,
  input  logic [cs_pkg::ENTRY_INDEX_W-1:0] entry_index,
  input  logic [cs_pkg::VALUE_W-1:0]       value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             found,
  output logic [cs_pkg::ENTRY_INDEX_W-1:0] chosen_index,
  input  logic                             cfg_wr_en,
  input  logic [cs_pkg::CFG_W-1:0]         cfg_wr_data
);
  import cs_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);

  cs_cmd_t       cmd;
  logic          hit;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] chk_idx;

  // Sequence the table walk
  cs_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .hit        (hit),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .chk_idx    (chk_idx)
  );

  // Hold the table, running sum and result
  cs_dp #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .PROB_BITS  (PROB_BITS)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .entry_index (entry_index),
    .value       (value),
    .rd_addr     (rd_addr),
    .chk_idx     (chk_idx),
    .hit         (hit),
    .found       (found),
    .chosen_index(chosen_index)
  );

endmodule

// ===== bench/categorical_sampler_top_test.sv =====
`timescale 1ns / 1ps

module categorical_sampler_top_test;
  import cs_pkg::*;

  // Idle cycles to wait after the last owed result has come out
  localparam int SETTLE_CYCLES = 72;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 60;

  typedef struct packed {
    logic                     hit;
    logic [ENTRY_INDEX_W-1:0] index;
  } draw_result_t;

  // How a phase fills the probability table
  typedef enum int {
    FILL_SPARSE,
    FILL_FINE,
    FILL_FULL,
    FILL_TINY
  } fill_t;

  // Mirror of the table and the draw walk; holds the draws still owed
  class draw_checker;
    logic [VALUE_W-1:0] probs [DEF_MAX_ENTRIES];
    logic [CFG_W-1:0]   entries_used;
    draw_result_t       owed_draws [$];
    int                 errors;

    function new();
      entries_used = '0;
      errors = 0;
    endfunction

    function void set_entries(logic [CFG_W-1:0] n);
      entries_used = n;
    endfunction

    // Apply a write, or walk the running sum for a draw
    function void note_request(mode_t m, logic [ENTRY_INDEX_W-1:0] idx,
                               logic [VALUE_W-1:0] v);
      int              count;
      int              i;
      longint unsigned running;
      draw_result_t    res;
      if (m == MODE_WRITE) begin
        probs[idx] = v;
        return;
      end
      count = (entries_used > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : int'(entries_used);
      running = 0;
      res = '0;
      for (i = 0; i < count; i++) begin
        running += probs[i];
        if (running > v) begin
          res.hit = 1'b1;
          res.index = ENTRY_INDEX_W'(i);
          break;
        end
      end
      owed_draws.push_back(res);
    endfunction

    // Compare a delivered result with the oldest draw owed
    function void check_draw(logic f, logic [ENTRY_INDEX_W-1:0] ci);
      draw_result_t want;
      if (owed_draws.size() == 0) begin
        $error("result with no draw outstanding: found %0d chosen_index %0d", f, ci);
        errors++;
        return;
      end
      want = owed_draws.pop_front();
      if (f !== want.hit) begin
        $error("found: expected %0d, actual %0d", want.hit, f);
        errors++;
      end
      if (ci !== want.index) begin
        $error("chosen_index: expected %0d, actual %0d", want.index, ci);
        errors++;
      end
    endfunction

    function int pending();
      return owed_draws.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     mode = 1'b0;
  logic [ENTRY_INDEX_W-1:0] entry_index = '0;
  logic [VALUE_W-1:0]       value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     found;
  logic [ENTRY_INDEX_W-1:0] chosen_index;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]         cfg_wr_data = '0;

  int          send_idle_pct = 24;
  int          recv_stall_pct = 54;
  draw_checker board;

  int    entries_plan [PHASES] = '{64, 127, 2, 17, 64, 100, 8, 40, 1};
  fill_t fill_plan [PHASES] = '{FILL_SPARSE, FILL_FINE, FILL_FULL, FILL_FINE, FILL_TINY,
                                FILL_SPARSE, FILL_FULL, FILL_FINE, FILL_FULL};

  categorical_sampler_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .entry_index  (entry_index),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .chosen_index (chosen_index),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Check each result that is taken at the coming edge
  always @(negedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      board.check_draw(found, chosen_index);
    end
  end

  // Present one request after a random gap; return at the edge that takes it
  task automatic send_request(input mode_t m, input logic [ENTRY_INDEX_W-1:0] idx,
                              input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    entry_index <= idx;
    value <= v;
    do @(negedge clk); while (in_stall);
    board.note_request(m, idx, v);
    @(posedge clk);
  endtask

  // Hold requests until every owed draw has come out, then settle
  task automatic drain_results(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_entries_used(input logic [CFG_W-1:0] n);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_entries(n);
  endtask

  function automatic logic [VALUE_W-1:0] pick_prob(fill_t f);
    case (f)
      FILL_SPARSE: return ($urandom_range(7) == 0) ? VALUE_W'($urandom) : '0;
      FILL_FINE:   return VALUE_W'($urandom_range(4095));
      FILL_TINY:   return VALUE_W'($urandom_range(1023));
      default:     return VALUE_W'($urandom_range(65535));
    endcase
  endfunction

  // Bias draws toward the ends of the range and the low part of the sum
  function automatic logic [VALUE_W-1:0] pick_draw();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    if (r < 30) return VALUE_W'($urandom_range(16383));
    return VALUE_W'($urandom_range(65535));
  endfunction

  task automatic run_phase(input int p);
    int    n;
    int    i;
    fill_t f;
    n = entries_plan[p];
    f = fill_plan[p];
    drain_results(SETTLE_CYCLES);
    send_idle_pct = (p < 3) ? 24 : (p < 6) ? 54 : 0;
    recv_stall_pct = (p < 3) ? 54 : (p < 6) ? 24 : 0;
    write_entries_used(CFG_W'(n));
    // Reload every entry that takes part in a draw
    for (i = 0; i < n && i < DEF_MAX_ENTRIES; i++) begin
      send_request(MODE_WRITE, ENTRY_INDEX_W'(i), pick_prob(f));
    end
    for (i = 0; i < PHASE_ITEMS; i++) begin
      if ($urandom_range(49) == 0) drain_results(0);
      if ($urandom_range(99) < 30) begin
        send_request(MODE_WRITE, ENTRY_INDEX_W'($urandom_range(63)), pick_prob(f));
      end else begin
        send_request(MODE_DRAW, ENTRY_INDEX_W'($urandom_range(63)), pick_draw());
      end
    end
  endtask

  initial begin
    int p;
    board = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // No entries in use: every draw misses
    send_request(MODE_DRAW, 6'd63, 16'h0000);
    send_request(MODE_DRAW, 6'd0, 16'hFFFF);
    send_request(MODE_WRITE, 6'd0, 16'h0000);
    send_request(MODE_WRITE, 6'd1, 16'h0001);
    send_request(MODE_WRITE, 6'd2, 16'h7FFF);
    send_request(MODE_WRITE, 6'd3, 16'h8000);
    send_request(MODE_WRITE, 6'd63, 16'hFFFF);
    drain_results(SETTLE_CYCLES);

    // Four entries: hits at the sum boundaries, then a table summing short
    write_entries_used(7'd4);
    send_request(MODE_DRAW, 6'd63, 16'h0000);
    send_request(MODE_DRAW, 6'd0, 16'h0001);
    send_request(MODE_DRAW, 6'd21, 16'h7FFF);
    send_request(MODE_DRAW, 6'd42, 16'h8000);
    send_request(MODE_DRAW, 6'd63, 16'hFFFF);
    send_request(MODE_WRITE, 6'd3, 16'h0000);
    send_request(MODE_DRAW, 6'd0, 16'hFFFF);
    send_request(MODE_DRAW, 6'd0, 16'h7FFF);

    for (p = 0; p < PHASES; p++) begin
      run_phase(p);
    end

    drain_results(SETTLE_CYCLES);
    if (board.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Stop a run that hangs
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== categorical_sampler_top.f =====
src/cs_pkg.sv
src/cs_ctrl.sv
src/cs_dp.sv
src/categorical_sampler_top.sv
bench/categorical_sampler_top_test.sv
